FILE: hdl/evp_pkg.sv
// ----------------------------------------------------------------------------
// evp_pkg: shared types and constants for the eased viewport pan block
// Operation codes, register indexes, step limits and the per-lane result.
// ----------------------------------------------------------------------------
`default_nettype none

package evp_pkg;

    localparam int COORD_W   = 16;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 8;
    localparam int STEP_W    = 4;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;

    localparam logic [COORD_W-1:0] HALF_W = COORD_W'(SCREEN_WIDTH / 2);
    localparam logic [COORD_W-1:0] HALF_H = COORD_W'(SCREEN_HEIGHT / 2);

    localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(12);

    localparam logic [FUNC_W-1:0] FUNC_TICK      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PAN_NOW   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PAN_ANIM  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_TO_SCREEN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BOUND_MIN_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_MAX_X = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_MIN_Y = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_MAX_Y = 8'd3;

    typedef logic signed [COORD_W-1:0] coord_t;

    // What one axis lane hands to the merge stage
    typedef struct packed {
        coord_t pos;
        coord_t tgt;
        coord_t screen;
        logic   differs;
    } axis_res_t;

endpackage

`default_nettype wire

FILE: hdl/eased_viewport_pan.sv
// ----------------------------------------------------------------------------
// eased_viewport_pan: 2-D scroll position with eased panning
// Result: registered, valid in the cycle after the input transfer.
// Throughput: one item per cycle unless m_ready stalls a full result register;
//   both axis lanes and the state update settle within the accept cycle.
// Reset: aresetn low clears position, target, bounds and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module eased_viewport_pan #(
    parameter int SCREEN_WIDTH  = evp_pkg::SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = evp_pkg::SCREEN_HEIGHT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    // Configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [evp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [evp_pkg::COORD_W-1:0]   cfg_data,

    // Input item channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [evp_pkg::FUNC_W-1:0]    s_func,
    input  wire evp_pkg::coord_t               s_world_x,
    input  wire evp_pkg::coord_t               s_world_y,

    // Result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output evp_pkg::coord_t                    m_view_x,
    output evp_pkg::coord_t                    m_view_y,
    output logic                               m_moved,
    output evp_pkg::coord_t                    m_screen_x,
    output evp_pkg::coord_t                    m_screen_y
);

    // Half-screen centering offsets handed to the lanes
    localparam logic [evp_pkg::COORD_W-1:0] HALF_X = (evp_pkg::COORD_W)'(SCREEN_WIDTH / 2);
    localparam logic [evp_pkg::COORD_W-1:0] HALF_Y = (evp_pkg::COORD_W)'(SCREEN_HEIGHT / 2);

    // Bound registers
    evp_pkg::coord_t min_x_reg, max_x_reg, min_y_reg, max_y_reg;

    // Scroll state
    evp_pkg::coord_t pos_x_reg, pos_y_reg, tgt_x_reg, tgt_y_reg;

    evp_pkg::axis_res_t res_x, res_y;
    logic               free;
    logic               accept;

    // Bound writes always complete; the user must write them only while idle, not enforced here
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg <= '0;
            max_x_reg <= '0;
            min_y_reg <= '0;
            max_y_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                evp_pkg::REG_BOUND_MIN_X: min_x_reg <= cfg_data;
                evp_pkg::REG_BOUND_MAX_X: max_x_reg <= cfg_data;
                evp_pkg::REG_BOUND_MIN_Y: min_y_reg <= cfg_data;
                evp_pkg::REG_BOUND_MAX_Y: max_y_reg <= cfg_data;
                default: ;  // drop writes outside the register list
            endcase
        end
    end

    // Accept while the result register is empty or being drained this cycle
    assign s_ready = free;
    assign accept  = s_valid && s_ready;

    // One lane per axis, working side by side on the same item
    evp_axis #(
        .HALF (HALF_X)
    ) u_lane_x (
        .func  (s_func),
        .world (s_world_x),
        .cur   (pos_x_reg),
        .tgt   (tgt_x_reg),
        .lo    (min_x_reg),
        .hi    (max_x_reg),
        .res   (res_x)
    );

    evp_axis #(
        .HALF (HALF_Y)
    ) u_lane_y (
        .func  (s_func),
        .world (s_world_y),
        .cur   (pos_y_reg),
        .tgt   (tgt_y_reg),
        .lo    (min_y_reg),
        .hi    (max_y_reg),
        .res   (res_y)
    );

    // Advance the scroll state on every accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            tgt_x_reg <= '0;
            tgt_y_reg <= '0;
        end else if (accept) begin
            pos_x_reg <= res_x.pos;
            pos_y_reg <= res_y.pos;
            tgt_x_reg <= res_x.tgt;
            tgt_y_reg <= res_y.tgt;
        end
    end

    // Merge lanes into the result register
    evp_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .func       (s_func),
        .res_x      (res_x),
        .res_y      (res_y),
        .free       (free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_view_x   (m_view_x),
        .m_view_y   (m_view_y),
        .m_moved    (m_moved),
        .m_screen_x (m_screen_x),
        .m_screen_y (m_screen_y)
    );

    // Every accepted transfer produces a result in the next cycle
    a_result_follows: assert property (
        @(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid
    ) else $error("result missing after input transfer");

    // Immediate pan leaves the position on its target
    a_pan_now_settles: assert property (
        @(posedge aclk) disable iff (!aresetn)
        accept && (s_func == evp_pkg::FUNC_PAN_NOW) |=>
            (pos_x_reg == tgt_x_reg) && (pos_y_reg == tgt_y_reg)
    ) else $error("immediate pan left position off target");

    // Screen offsets are zero unless the transfer asked for them, and view X equals position X
    a_screen_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        accept && (s_func != evp_pkg::FUNC_TO_SCREEN) |=>
            (m_screen_x == '0) && (m_screen_y == '0) && (m_view_x == pos_x_reg)
    ) else $error("screen offset or view mismatch");

endmodule

`default_nettype wire

FILE: hdl/evp_axis.sv
// ----------------------------------------------------------------------------
// evp_axis: one axis lane
// Clamped aim point, eased step toward the target, and world-to-screen offset.
// ----------------------------------------------------------------------------
`default_nettype none

module evp_axis #(
    parameter logic [evp_pkg::COORD_W-1:0] HALF = evp_pkg::HALF_W
) (
    input  wire logic [evp_pkg::FUNC_W-1:0] func,
    input  wire evp_pkg::coord_t            world,
    input  wire evp_pkg::coord_t            cur,
    input  wire evp_pkg::coord_t            tgt,
    input  wire evp_pkg::coord_t            lo,
    input  wire evp_pkg::coord_t            hi,
    output evp_pkg::axis_res_t              res
);

    evp_pkg::coord_t                  aim;
    evp_pkg::coord_t                  aim_c;
    evp_pkg::coord_t                  delta;
    logic [evp_pkg::COORD_W-1:0]      mag;
    logic [evp_pkg::COORD_W-5:0]      shifted;
    logic [evp_pkg::STEP_W-1:0]       step;
    logic                             snap;
    evp_pkg::coord_t                  eased;

    always_comb begin
        // Centering offset wraps before the clamp; on inverted bounds, aims below min take min, others max
        aim = world - $signed(HALF);
        if (aim < lo) begin
            aim_c = lo;
        end else if (aim > hi) begin
            aim_c = hi;
        end else begin
            aim_c = aim;
        end

        delta   = tgt - cur;
        mag     = delta[evp_pkg::COORD_W-1] ? -delta : delta;
        shifted = mag[evp_pkg::COORD_W-2:3];

        // Largest distance: magnitude wraps negative, step drops to the minimum
        if (mag[evp_pkg::COORD_W-1]) begin
            step = evp_pkg::STEP_MIN;
        end else if (shifted == '0) begin
            step = evp_pkg::STEP_MIN;
        end else if (shifted > (evp_pkg::COORD_W-4)'(evp_pkg::STEP_MAX)) begin
            step = evp_pkg::STEP_MAX;
        end else begin
            step = shifted[evp_pkg::STEP_W-1:0];
        end

        snap = mag <= evp_pkg::COORD_W'(step);
        if (snap) begin
            eased = tgt;
        end else if (delta[evp_pkg::COORD_W-1]) begin
            eased = cur - $signed(evp_pkg::COORD_W'(step));
        end else begin
            eased = cur + $signed(evp_pkg::COORD_W'(step));
        end

        res.differs = cur != tgt;
        res.screen  = '0;
        unique case (func)
            evp_pkg::FUNC_TICK: begin
                res.pos = eased;
                res.tgt = tgt;
            end
            evp_pkg::FUNC_PAN_NOW: begin
                res.pos = aim_c;
                res.tgt = aim_c;
            end
            evp_pkg::FUNC_PAN_ANIM: begin
                res.pos = cur;
                res.tgt = aim_c;
            end
            default: begin
                res.pos    = cur;
                res.tgt    = tgt;
                res.screen = world - cur;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/evp_merge.sv
// ----------------------------------------------------------------------------
// evp_merge: lane merge and result register
// Combine both lanes into one result and hold it until the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module evp_merge (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       load,
    input  wire logic [evp_pkg::FUNC_W-1:0] func,
    input  wire evp_pkg::axis_res_t         res_x,
    input  wire evp_pkg::axis_res_t         res_y,
    output logic                            free,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output evp_pkg::coord_t                 m_view_x,
    output evp_pkg::coord_t                 m_view_y,
    output logic                            m_moved,
    output evp_pkg::coord_t                 m_screen_x,
    output evp_pkg::coord_t                 m_screen_y
);

    logic            valid_reg;
    logic            valid_next;
    evp_pkg::coord_t view_x_reg;
    evp_pkg::coord_t view_y_reg;
    logic            moved_reg;
    evp_pkg::coord_t screen_x_reg;
    evp_pkg::coord_t screen_y_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload: load only, no reset needed
    always_ff @(posedge aclk) begin
        if (load) begin
            view_x_reg   <= res_x.pos;
            view_y_reg   <= res_y.pos;
            moved_reg    <= (func == evp_pkg::FUNC_TICK) && (res_x.differs || res_y.differs);
            screen_x_reg <= res_x.screen;
            screen_y_reg <= res_y.screen;
        end
    end

    assign m_valid    = valid_reg;
    assign m_view_x   = view_x_reg;
    assign m_view_y   = view_y_reg;
    assign m_moved    = moved_reg;
    assign m_screen_x = screen_x_reg;
    assign m_screen_y = screen_y_reg;

endmodule

`default_nettype wire
